@@ rtl/modbus_rtu_read_holding_master_top_macros.svh @@
// Assertion macros for the Modbus RTU read-holding master.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef MODBUS_RTU_READ_HOLDING_MASTER_TOP_MACROS_SVH
`define MODBUS_RTU_READ_HOLDING_MASTER_TOP_MACROS_SVH

// same-cycle implication
`define MRH_ASSERT_NOW(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define MRH_ASSERT_NEXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) else $error(msg);

`endif

@@ rtl/mrh_pkg.sv @@
// Shared codes and constants for the Modbus RTU read-holding master.
// No dependencies.
`timescale 1ns / 1ps

package mrh_pkg;

    localparam int OP_W   = 2;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_REQ  = 2'd0,
        KIND_REG  = 2'd1,
        KIND_STAT = 2'd2
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_EXC     = 2'd2,
        ST_CRC     = 2'd3
    } t_stat;

    typedef enum logic [1:0] {
        CFG_SLAVE   = 2'd0,
        CFG_START   = 2'd1,
        CFG_COUNT   = 2'd2,
        CFG_TIMEOUT = 2'd3
    } t_cfg_idx;

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [7:0]  FUNC_RDHOLD = 8'h03;
    localparam int          EXC_BIT     = 7;

    localparam logic [7:0]  SLAVE_RST   = 8'd1;
    localparam logic [15:0] START_RST   = 16'd0;
    localparam logic [4:0]  COUNT_RST   = 5'd1;
    localparam logic [15:0] TIMEOUT_RST = 16'd500;

    localparam int MAX_REGS_DEF = 16;

endpackage

@@ rtl/modbus_rtu_read_holding_master_top.sv @@
// Modbus RTU function 03 master: request framing, response parsing, timeout.
// Depends on mrh_pkg and modbus_rtu_read_holding_master_top_macros.svh.
//
//   channel | valid        | stall        | payload
//   --------+--------------+--------------+--------------------------------------
//   in      | i_in_valid   | o_in_stall   | i_operation, i_rx_byte
//   out     | o_out_valid  | i_out_stall  | o_kind .. o_last
//   cfg     | i_cfg_we     | -            | i_cfg_index, i_cfg_data
//
// CRC runs one bit per cycle: in S_TXSHIFT for each of the six request bytes and
// in S_RXSHIFT for each response byte ahead of the two CRC bytes. The final byte
// of a good response reads the register store back, one register at a time.
// Input is stalled while that work runs or an item waits to be registered.
// Synchronous active-low reset; no clearing pass.
`timescale 1ns / 1ps
`include "modbus_rtu_read_holding_master_top_macros.svh"

module modbus_rtu_read_holding_master_top #(
    parameter int MAX_REGISTERS = mrh_pkg::MAX_REGS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [mrh_pkg::OP_W-1:0]   i_operation,
    input  logic [7:0]                 i_rx_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [mrh_pkg::KIND_W-1:0] o_kind,
    output logic [7:0]                 o_tx_byte,
    output logic [3:0]                 o_reg_index,
    output logic [15:0]                o_reg_value,
    output logic [mrh_pkg::STAT_W-1:0] o_status,
    output logic [7:0]                 o_exception_code,
    output logic                       o_last,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [15:0]                i_cfg_data
);
    import mrh_pkg::*;

    localparam int NW = $clog2(MAX_REGISTERS + 1);
    localparam int AW = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1;
    localparam int PW = $clog2(2 * MAX_REGISTERS + 6);

    typedef enum logic [2:0] {
        S_IDLE, S_TXLOAD, S_TXSHIFT, S_TXEMIT, S_RXSHIFT, S_RDREQ, S_RDOUT, S_STAT
    } t_state;

    t_state        r_state;
    logic [7:0]    r_slave;
    logic [15:0]   r_start;
    logic [4:0]    r_count;
    logic [15:0]   r_timeout;
    logic          r_wait;
    logic [PW-1:0] r_pos;
    logic [15:0]   r_crc;
    logic [7:0]    r_func;
    logic [7:0]    r_third;
    logic [7:0]    r_pend;
    logic [15:0]   r_elapsed;
    logic [NW-1:0] r_n;
    logic [NW-1:0] r_idx;
    logic [2:0]    r_i;
    logic [2:0]    r_bit;
    t_stat         r_stat;
    logic [15:0]   r_rd_data;
    logic [15:0]   r_mem [MAX_REGISTERS];

    logic          r_ov;
    logic [1:0]    r_kind;
    logic [7:0]    r_tx;
    logic [3:0]    r_ridx;
    logic [15:0]   r_rval;
    logic [1:0]    r_st;
    logic [7:0]    r_exc;
    logic          r_last;

    logic          w_acc;
    logic          w_out_free;
    logic          w_emit;
    logic [NW-1:0] w_n_eff;
    logic [7:0]    w_req;
    logic [15:0]   w_crc_step;
    logic [PW-1:0] w_lim;
    logic [PW-1:0] w_d;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [15:0]   w_el_nx;

    assign w_acc      = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_ov || !i_out_stall;
    assign w_emit     = w_out_free && ((r_state == S_TXEMIT) || (r_state == S_RDOUT)
                                       || (r_state == S_STAT));
    assign w_crc_step = r_crc[0] ? ((r_crc >> 1) ^ CRC_POLY) : (r_crc >> 1);
    assign w_lim      = PW'({r_n, 1'b0}) + PW'(3);
    assign w_d        = r_pos - PW'(3);
    assign w_el_nx    = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;

    // zero acts as one, above the store depth clamps to it
    always_comb begin
        if (r_count == 5'd0) begin
            w_n_eff = NW'(1);
        end else if (8'(r_count) > 8'(MAX_REGISTERS)) begin
            w_n_eff = NW'(MAX_REGISTERS);
        end else begin
            w_n_eff = NW'(r_count);
        end
    end

    always_comb begin
        unique case (r_i)
            3'd0:    w_req = r_slave;
            3'd1:    w_req = FUNC_RDHOLD;
            3'd2:    w_req = r_start[15:8];
            3'd3:    w_req = r_start[7:0];
            3'd4:    w_req = 8'(16'(r_n) >> 8);
            3'd5:    w_req = 8'(r_n);
            3'd6:    w_req = r_crc[7:0];
            default: w_req = r_crc[15:8];
        endcase
    end

    // odd data byte completes a register
    assign w_we    = w_acc && r_wait && (t_op'(i_operation) == OP_BYTE)
                     && (r_pos < w_lim) && (r_pos >= PW'(3)) && w_d[0];
    assign w_waddr = AW'(w_d >> 1);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= {r_pend, i_rx_byte};
        end
        r_rd_data <= r_mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_slave   <= SLAVE_RST;
            r_start   <= START_RST;
            r_count   <= COUNT_RST;
            r_timeout <= TIMEOUT_RST;
            r_wait    <= 1'b0;
            r_pos     <= '0;
            r_crc     <= CRC_INIT;
            r_func    <= '0;
            r_third   <= '0;
            r_pend    <= '0;
            r_elapsed <= '0;
            r_n       <= NW'(1);
            r_idx     <= '0;
            r_i       <= '0;
            r_bit     <= '0;
            r_stat    <= ST_OK;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_SLAVE:   r_slave   <= i_cfg_data[7:0];
                    CFG_START:   r_start   <= i_cfg_data;
                    CFG_COUNT:   r_count   <= i_cfg_data[4:0];
                    CFG_TIMEOUT: r_timeout <= i_cfg_data;
                endcase
            end

            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        priority case (t_op'(i_operation))
                            OP_START: begin
                                r_n       <= w_n_eff;
                                r_wait    <= 1'b1;
                                r_pos     <= '0;
                                r_crc     <= CRC_INIT;
                                r_func    <= '0;
                                r_third   <= '0;
                                r_pend    <= '0;
                                r_elapsed <= '0;
                                r_i       <= '0;
                                r_state   <= S_TXLOAD;
                            end
                            OP_BYTE: begin
                                if (r_wait) begin
                                    if (r_pos < w_lim) begin
                                        r_crc   <= r_crc ^ {8'h00, i_rx_byte};
                                        r_bit   <= '0;
                                        r_state <= S_RXSHIFT;
                                        if (r_pos == PW'(1)) begin
                                            r_func <= i_rx_byte;
                                        end else if (r_pos == PW'(2)) begin
                                            r_third <= i_rx_byte;
                                        end else if (r_pos >= PW'(3) && !w_d[0]) begin
                                            r_pend <= i_rx_byte;
                                        end
                                        r_pos <= r_pos + PW'(1);
                                    end else if (r_pos == w_lim) begin
                                        r_pend <= i_rx_byte;
                                        r_pos  <= r_pos + PW'(1);
                                    end else begin
                                        r_wait <= 1'b0;
                                        r_pos  <= '0;
                                        // exception wins over CRC
                                        if (r_func[EXC_BIT]) begin
                                            r_stat  <= ST_EXC;
                                            r_state <= S_STAT;
                                        end else if ({i_rx_byte, r_pend} != r_crc) begin
                                            r_stat  <= ST_CRC;
                                            r_state <= S_STAT;
                                        end else begin
                                            r_idx   <= '0;
                                            r_state <= S_RDREQ;
                                        end
                                    end
                                end
                            end
                            OP_TICK: begin
                                if (r_wait) begin
                                    r_elapsed <= w_el_nx;
                                    if (w_el_nx >= r_timeout) begin
                                        r_wait  <= 1'b0;
                                        r_stat  <= ST_TIMEOUT;
                                        r_state <= S_STAT;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_TXLOAD: begin
                    if (r_i < 3'd6) begin
                        r_crc   <= r_crc ^ {8'h00, w_req};
                        r_bit   <= '0;
                        r_state <= S_TXSHIFT;
                    end else begin
                        r_state <= S_TXEMIT;
                    end
                end
                S_TXSHIFT: begin
                    r_crc <= w_crc_step;
                    r_bit <= r_bit + 3'd1;
                    if (r_bit == 3'd7) begin
                        r_state <= S_TXEMIT;
                    end
                end
                S_TXEMIT: begin
                    if (w_out_free) begin
                        r_kind <= KIND_REQ;
                        r_tx   <= w_req;
                        r_ridx <= '0;
                        r_rval <= '0;
                        r_st   <= ST_OK;
                        r_exc  <= '0;
                        r_last <= (r_i == 3'd7);
                        if (r_i == 3'd7) begin
                            r_crc   <= CRC_INIT;
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + 3'd1;
                            r_state <= S_TXLOAD;
                        end
                    end
                end
                S_RXSHIFT: begin
                    r_crc <= w_crc_step;
                    r_bit <= r_bit + 3'd1;
                    if (r_bit == 3'd7) begin
                        r_state <= S_IDLE;
                    end
                end
                S_RDREQ: begin
                    r_state <= S_RDOUT;
                end
                S_RDOUT: begin
                    if (w_out_free) begin
                        r_kind <= KIND_REG;
                        r_tx   <= '0;
                        r_ridx <= 4'(r_idx);
                        r_rval <= r_rd_data;
                        r_st   <= ST_OK;
                        r_exc  <= '0;
                        r_last <= 1'b0;
                        if (r_idx == r_n - NW'(1)) begin
                            r_stat  <= ST_OK;
                            r_state <= S_STAT;
                        end else begin
                            r_idx   <= r_idx + NW'(1);
                            r_state <= S_RDREQ;
                        end
                    end
                end
                S_STAT: begin
                    if (w_out_free) begin
                        r_kind  <= KIND_STAT;
                        r_tx    <= '0;
                        r_ridx  <= '0;
                        r_rval  <= '0;
                        r_st    <= r_stat;
                        r_exc   <= (r_stat == ST_EXC) ? r_third : 8'h00;
                        r_last  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_ov;
    assign o_kind           = r_kind;
    assign o_tx_byte        = r_tx;
    assign o_reg_index      = r_ridx;
    assign o_reg_value      = r_rval;
    assign o_status         = r_st;
    assign o_exception_code = r_exc;
    assign o_last           = r_last;

    `MRH_ASSERT_NOW(a_reg_after_wait, o_out_valid && (o_kind == KIND_REG), !r_wait,
        "register item while response still pending")
    `MRH_ASSERT_NOW(a_last_kind, o_out_valid && o_last,
        (o_kind == KIND_STAT) || (o_kind == KIND_REQ), "last flag on register item")
    `MRH_ASSERT_NEXT(a_start_waits,
        w_acc && (t_op'(i_operation) == OP_START), r_wait && (r_state == S_TXLOAD),
        "start item did not arm the response wait")

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the Modbus RTU function 03 master.
// Depends on mrh_pkg and modbus_rtu_read_holding_master_top; drives request/response exchanges.
`timescale 1ns / 1ps

module testbench;
    import mrh_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [3:0]  reg_index;
        logic [15:0] reg_value;
        logic [1:0]  status;
        logic [7:0]  exception_code;
        logic        last;
    } t_res;

    typedef struct {
        t_op        op;
        logic [7:0] rx;
        bit         typed;   // expected results typed in below
        int         n_res;
        t_res       res0;
    } t_row;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    logic [1:0]  i_operation = OP_NONE;
    logic [7:0]  i_rx_byte = 0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    logic [1:0]  o_kind;
    logic [7:0]  o_tx_byte;
    logic [3:0]  o_reg_index;
    logic [15:0] o_reg_value;
    logic [1:0]  o_status;
    logic [7:0]  o_exception_code;
    logic        o_last;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_index = CFG_SLAVE;
    logic [15:0] i_cfg_data = 0;

    modbus_rtu_read_holding_master_top DUT (.*);

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [7:0]  cfg_slave;
    logic [15:0] first_reg;
    logic [4:0]  reg_cnt;
    logic [15:0] timeout_ticks;
    bit          awaiting;
    int          rx_count;
    logic [15:0] rx_crc;
    logic [7:0]  func_byte, third_b, held_byte;
    logic [15:0] reg_mem [16];
    logic [15:0] ticks_seen;
    int          act_cnt;

    t_res expected_q[$];
    int   errors = 0;
    bit   long_hold = 0;
    int   burst_left = 0;

    function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
        c ^= {8'h00, b};
        for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic t_res mk(logic [1:0] k, logic [7:0] tx, logic [3:0] ix,
                                logic [15:0] v, logic [1:0] s, logic [7:0] e, logic l);
        t_res r;
        r.kind = k; r.tx_byte = tx; r.reg_index = ix; r.reg_value = v;
        r.status = s; r.exception_code = e; r.last = l;
        return r;
    endfunction

    task automatic predictor_reset();
        cfg_slave = SLAVE_RST; first_reg = START_RST; reg_cnt = COUNT_RST;
        timeout_ticks = TIMEOUT_RST; awaiting = 0; rx_count = 0; rx_crc = CRC_INIT;
        func_byte = 0; third_b = 0; held_byte = 0; ticks_seen = 0; act_cnt = 1;
    endtask

    // Computes the results of one item into res and updates the predictor state.
    task automatic predict_master(t_op op, logic [7:0] b, ref t_res res[$]);
        logic [7:0]  frame[8];
        logic [15:0] c;
        int          n, total;
        res = {};
        if (op == OP_START) begin
            n = reg_cnt == 0 ? 1 : (reg_cnt > 16 ? 16 : reg_cnt);
            frame[0] = cfg_slave; frame[1] = FUNC_RDHOLD;
            frame[2] = first_reg[15:8]; frame[3] = first_reg[7:0];
            frame[4] = 8'h00; frame[5] = n[7:0];
            c = CRC_INIT;
            for (int i = 0; i < 6; i++) c = crc16_byte(c, frame[i]);
            frame[6] = c[7:0]; frame[7] = c[15:8];
            for (int i = 0; i < 8; i++)
                res.push_back(mk(KIND_REQ, frame[i], 4'd0, 16'd0, ST_OK, 8'd0, i == 7));
            act_cnt = n; awaiting = 1; rx_count = 0; rx_crc = CRC_INIT;
            func_byte = 0; third_b = 0; held_byte = 0; ticks_seen = 0;
            return;
        end
        if (!awaiting || op == OP_NONE) return;
        if (op == OP_TICK) begin
            if (ticks_seen != 16'hFFFF) ticks_seen++;
            if (ticks_seen >= timeout_ticks) begin
                awaiting = 0;
                res.push_back(mk(KIND_STAT, 8'd0, 4'd0, 16'd0, ST_TIMEOUT, 8'd0, 1'b1));
            end
            return;
        end
        total = 5 + 2 * act_cnt;
        if (rx_count + 2 < total) begin
            rx_crc = crc16_byte(rx_crc, b);
            if (rx_count == 1) func_byte = b;
            else if (rx_count == 2) third_b = b;
            else if (rx_count >= 3) begin
                if (((rx_count - 3) & 1) == 0) held_byte = b;
                else reg_mem[((rx_count - 3) >> 1) & 15] = {held_byte, b};
            end
            rx_count++;
        end else if (rx_count + 2 == total) begin
            held_byte = b;
            rx_count++;
        end else begin
            awaiting = 0; rx_count = 0;
            if (func_byte[EXC_BIT])
                res.push_back(mk(KIND_STAT, 8'd0, 4'd0, 16'd0, ST_EXC, third_b, 1'b1));
            else if ({b, held_byte} != rx_crc)
                res.push_back(mk(KIND_STAT, 8'd0, 4'd0, 16'd0, ST_CRC, 8'd0, 1'b1));
            else begin
                for (int i = 0; i < act_cnt; i++)
                    res.push_back(mk(KIND_REG, 8'd0, i[3:0], reg_mem[i], ST_OK, 8'd0, 1'b0));
                res.push_back(mk(KIND_STAT, 8'd0, 4'd0, 16'd0, ST_OK, 8'd0, 1'b1));
            end
        end
    endtask

    // writes only with no item on the input and nothing pending at the output
    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        i_in_valid = 0;
        burst_left = 0;
        @(negedge i_clk);
        while (o_in_stall || expected_q.size() != 0) @(negedge i_clk);
        i_cfg_we = 1; i_cfg_index = idx; i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 0;
        case (idx)
            CFG_SLAVE:   cfg_slave = val[7:0];
            CFG_START:   first_reg = val;
            CFG_COUNT:   reg_cnt = val[4:0];
            CFG_TIMEOUT: timeout_ticks = val;
        endcase
    endtask

    // Sends one item at the falling edge, waits for acceptance; bursts and gaps.
    task automatic send_item(t_op op, logic [7:0] b);
        t_res res[$];
        if (burst_left == 0) begin
            i_in_valid = 0;
            repeat ($urandom_range(0, 1) ? $urandom_range(1, 6) : 0) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid = 1; i_operation = op; i_rx_byte = b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_master(op, b, res);
        foreach (res[i]) expected_q.push_back(res[i]);
        @(negedge i_clk);
        if (burst_left == 0) i_in_valid = 0;
    endtask

    task automatic drain();
        i_in_valid = 0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    // One whole response frame; mode 0 good, 1 bad CRC, 2 exception
    task automatic send_response(int mode);
        logic [7:0]  f[$];
        logic [15:0] c;
        f.push_back(cfg_slave);
        f.push_back(mode == 2 ? (FUNC_RDHOLD | 8'h80) : FUNC_RDHOLD);
        f.push_back(mode == 2 ? 8'($urandom_range(0, 255)) : 8'(2 * act_cnt));
        for (int i = 0; i < 2 * act_cnt; i++) f.push_back(8'($urandom_range(0, 255)));
        c = CRC_INIT;
        foreach (f[i]) c = crc16_byte(c, f[i]);
        if (mode == 1) c ^= 16'(1 << $urandom_range(0, 15));
        f.push_back(c[7:0]); f.push_back(c[15:8]);
        foreach (f[i]) begin
            if ($urandom_range(0, 9) == 0) send_item(OP_TICK, 8'($urandom_range(0, 255)));
            send_item(OP_BYTE, f[i]);
        end
    endtask

    // output checker
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = mk(o_kind, o_tx_byte, o_reg_index, o_reg_value, o_status,
                     o_exception_code, o_last);
            if (expected_q.size() == 0) begin
                $error("unexpected result item %p", got);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (got.kind != want.kind) begin
                    $error("kind exp %0d got %0d", want.kind, got.kind); errors++; end
                if (got.tx_byte != want.tx_byte) begin
                    $error("tx_byte exp %0h got %0h", want.tx_byte, got.tx_byte); errors++; end
                if (got.reg_index != want.reg_index) begin
                    $error("reg_index exp %0d got %0d", want.reg_index, got.reg_index); errors++; end
                if (got.reg_value != want.reg_value) begin
                    $error("reg_value exp %0h got %0h", want.reg_value, got.reg_value); errors++; end
                if (got.status != want.status) begin
                    $error("status exp %0d got %0d", want.status, got.status); errors++; end
                if (got.exception_code != want.exception_code) begin
                    $error("exception_code exp %0h got %0h", want.exception_code,
                           got.exception_code);
                    errors++;
                end
                if (got.last != want.last) begin
                    $error("last exp %0d got %0d", want.last, got.last); errors++; end
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    always @(negedge i_clk) begin
        int hold;
        if (long_hold) begin
            i_out_stall <= 1;
            for (hold = 0; hold < 400; hold++) @(negedge i_clk);
            long_hold = 0;
            i_out_stall <= 0;
        end else if (($urandom_range(0, 63) < 8))
            i_out_stall <= 0;
        else
            i_out_stall <= ($time / 1000) % 2 == 0 ? ($urandom_range(0, 3) == 0) : 1'b0;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_row rows[$];
        t_row r;
        t_res res[$];
        predictor_reset();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1;

        // directed: idle noise, reset request, timeout, exception, crc, extremes
        r = '{OP_BYTE, 8'hFF, 1, 0, '0};                         rows.push_back(r);
        r = '{OP_TICK, 8'h00, 1, 0, '0};                         rows.push_back(r);
        r = '{OP_NONE, 8'hAA, 1, 0, '0};                         rows.push_back(r);
        // reset request frame: 01 03 00 00 00 01 84 0A
        r = '{OP_START, 8'h00, 1, 8,
              mk(KIND_REQ, 8'h01, 4'd0, 16'd0, ST_OK, 8'd0, 1'b0)};
        rows.push_back(r);
        foreach (rows[i]) begin
            predict_master(rows[i].op, rows[i].rx, res);
            if (rows[i].typed && res.size() != rows[i].n_res) begin
                $error("row %0d result count exp %0d got %0d", i, rows[i].n_res, res.size());
                errors++;
            end
            if (rows[i].typed && res.size() > 0 && res[0] != rows[i].res0) begin
                $error("row %0d first result differs", i); errors++;
            end
            // undo predictor side effect; send_item predicts again
            if (rows[i].op == OP_START) begin
                awaiting = 0;
            end
            send_item(rows[i].op, rows[i].rx);
        end
        send_response(0);
        drain();

        write_reg(CFG_TIMEOUT, 16'd1);
        send_item(OP_START, 8'h00); send_item(OP_TICK, 8'h00);
        write_reg(CFG_TIMEOUT, 16'd0);
        send_item(OP_START, 8'h00); send_item(OP_TICK, 8'h00);
        drain();
        write_reg(CFG_TIMEOUT, 16'hFFFF);
        write_reg(CFG_SLAVE, 16'h00FF); write_reg(CFG_START, 16'hFFFF);
        write_reg(CFG_COUNT, 16'd2);
        send_item(OP_START, 8'h00); send_response(2);
        send_item(OP_START, 8'h00); send_response(1);
        write_reg(CFG_COUNT, 16'd16);
        send_item(OP_START, 8'h00); send_item(OP_BYTE, 8'h00); send_item(OP_START, 8'h00);
        send_response(0);
        drain();
        write_reg(CFG_COUNT, 16'd0); write_reg(CFG_SLAVE, 16'h0000);
        write_reg(CFG_START, 16'h0000);
        send_item(OP_START, 8'h00); send_response(0);
        drain();
        write_reg(CFG_COUNT, 16'd31);
        send_item(OP_START, 8'h00); send_response(0);
        drain();

        // pressure: long receiver hold while requests keep coming
        long_hold = 1;
        write_reg(CFG_COUNT, 16'd4);
        for (int i = 0; i < 2; i++) begin
            send_item(OP_START, 8'h00); send_response(0);
        end
        drain();

        // random phases
        for (int ph = 0; ph < 2; ph++) begin
            write_reg(CFG_SLAVE, 16'($urandom_range(0, 255)));
            write_reg(CFG_START, 16'($urandom_range(0, 65535)));
            write_reg(CFG_COUNT, ph == 1 ? 16'd1 : 16'($urandom_range(0, 6)));
            write_reg(CFG_TIMEOUT,
                      $urandom_range(0, 3) == 0 ? 16'($urandom_range(1, 8)) : 16'd60000);
            for (int k = 0; k < 4; k++) begin
                int sel;
                sel = $urandom_range(0, 9);
                send_item(OP_START, 8'($urandom_range(0, 255)));
                if (sel < 6) send_response(0);
                else if (sel == 6) send_response(1);
                else if (sel == 7) send_response(2);
                else if (sel == 8)
                    repeat (10) send_item(OP_TICK, 8'($urandom_range(0, 255)));
                else begin
                    repeat ($urandom_range(0, 5))
                        send_item(t_op'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
                end
            end
            drain();
        end

        if (errors == 0 && expected_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
